// ===== design/ptidx_pkg.sv =====
// Shared types and constants for the periodic tile index unit.
// No dependencies; every other design file imports this package.
package ptidx_pkg;

    localparam int NUM_COORDS = 3;
    localparam int COORD_W    = 5;
    localparam int INDEX_W    = 15;
    localparam int DEPTH_W    = 4;
    localparam int DIMS_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH       = 2'd0,
        REG_ACTIVE_DIMS = 2'd1,
        REG_ZERO_TILE   = 2'd2,
        REG_NEG_HALF    = 2'd3
    } ptidx_reg_t;

    // Control that travels with an item down the pipeline.
    typedef struct packed {
        logic              inrange;
        logic [DIMS_W-1:0] dims;
    } ptidx_ctl_t;

endpackage

// ===== design/periodic_tile_index_unit.sv =====
// Top level of the periodic tile index unit.
// Depends on ptidx_pkg, ptidx_prep, ptidx_mac and ptidx_rank.

// The unit takes one tile offset (up to three signed coordinates) per item
// and returns whether that tile is in the periodic image list and at which
// row. It accepts one item every clock cycle while in_stall is low. The
// four register stages are the range check and offset stage, two
// multiply-accumulate stages that each fold one more coordinate into a
// base 2*depth+1 value (two 15 by 5 bit multiplies each, one for the value
// and one for the tile count), and the compare stage that ranks the value
// against the centre tile and holds the output register. A stall on the
// output side holds the output stage and each full stage right behind it;
// stages behind a gap move up. It reaches the input stall only once all
// stages are full, so no item is lost or repeated. Configuration registers
// should be written only while the pipeline is empty.
module periodic_tile_index_unit #(
    parameter int MAX_DIMS  = 3,
    parameter int MAX_DEPTH = 15
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [ptidx_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ptidx_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [ptidx_pkg::COORD_W-1:0]    coord_0,
    input  logic signed [ptidx_pkg::COORD_W-1:0]    coord_1,
    input  logic signed [ptidx_pkg::COORD_W-1:0]    coord_2,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    found,
    output logic [ptidx_pkg::INDEX_W-1:0]           tile_index
);
    import ptidx_pkg::*;

    // Only three coordinates exist on the ports, so the dimension clamp
    // never exceeds three.
    localparam int EFF_DIMS = (MAX_DIMS < NUM_COORDS) ? MAX_DIMS : NUM_COORDS;
    localparam int GMAX     = 2 * MAX_DEPTH + 1;
    localparam int GW       = $clog2(GMAX + 1);
    localparam int UW       = $clog2(GMAX);
    localparam int VW       = $clog2(GMAX ** EFF_DIMS + 1);

    // Configuration registers.
    logic [DEPTH_W-1:0] depth_reg;
    logic [DIMS_W-1:0]  dims_reg;
    logic               zero_reg;
    logic               neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_W'(1);
            dims_reg  <= DIMS_W'(3);
            zero_reg  <= 1'b1;
            neg_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (ptidx_reg_t'(cfg_index))
                REG_DEPTH:       depth_reg <= cfg_wdata[DEPTH_W-1:0];
                REG_ACTIVE_DIMS: dims_reg  <= cfg_wdata[DIMS_W-1:0];
                REG_ZERO_TILE:   zero_reg  <= cfg_wdata[0];
                REG_NEG_HALF:    neg_reg   <= cfg_wdata[0];
                default:         depth_reg <= depth_reg;
            endcase
        end
    end

    // Stage interconnect.
    logic signed [COORD_W-1:0] coord [NUM_COORDS];

    logic              s1_valid, s1_ready;
    ptidx_ctl_t        s1_ctl;
    logic [GW-1:0]     s1_g;
    logic [VW-1:0]     s1_acc, s1_n;
    logic [UW-1:0]     s1_u [NUM_COORDS];

    logic              s2_valid, s2_ready;
    ptidx_ctl_t        s2_ctl;
    logic [GW-1:0]     s2_g;
    logic [VW-1:0]     s2_acc, s2_n;
    logic [UW-1:0]     s2_u [NUM_COORDS];

    logic              s3_valid, s3_ready;
    ptidx_ctl_t        s3_ctl;
    logic [VW-1:0]     s3_acc, s3_n;

    logic              s4_ready;

    assign coord[0] = coord_0;
    assign coord[1] = coord_1;
    assign coord[2] = coord_2;

    assign in_stall = !s1_ready;

    // Stage 1: clamp the configuration, range-check and offset coordinates.
    ptidx_prep #(
        .MAX_DEPTH (MAX_DEPTH),
        .EFF_DIMS  (EFF_DIMS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_depth (depth_reg),
        .cfg_dims  (dims_reg),
        .valid_in  (in_valid),
        .ready_up  (s1_ready),
        .coord     (coord),
        .ready_dn  (s2_ready),
        .valid_out (s1_valid),
        .ctl_out   (s1_ctl),
        .g_out     (s1_g),
        .acc_out   (s1_acc),
        .n_out     (s1_n),
        .u_out     (s1_u)
    );

    // Stage 2: fold in the second coordinate.
    ptidx_mac #(
        .MAX_DEPTH (MAX_DEPTH),
        .EFF_DIMS  (EFF_DIMS),
        .STEP      (1)
    ) u_mac1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .ready_up  (s2_ready),
        .ctl_in    (s1_ctl),
        .g_in      (s1_g),
        .acc_in    (s1_acc),
        .n_in      (s1_n),
        .u_in      (s1_u),
        .ready_dn  (s3_ready),
        .valid_out (s2_valid),
        .ctl_out   (s2_ctl),
        .g_out     (s2_g),
        .acc_out   (s2_acc),
        .n_out     (s2_n),
        .u_out     (s2_u)
    );

    // Stage 3: fold in the third coordinate.
    ptidx_mac #(
        .MAX_DEPTH (MAX_DEPTH),
        .EFF_DIMS  (EFF_DIMS),
        .STEP      (2)
    ) u_mac2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .ready_up  (s3_ready),
        .ctl_in    (s2_ctl),
        .g_in      (s2_g),
        .acc_in    (s2_acc),
        .n_in      (s2_n),
        .u_in      (s2_u),
        .ready_dn  (s4_ready),
        .valid_out (s3_valid),
        .ctl_out   (s3_ctl),
        .g_out     (),
        .acc_out   (s3_acc),
        .n_out     (s3_n),
        .u_out     ()
    );

    // Stage 4: rank against the centre tile; this is the output register.
    ptidx_rank #(
        .MAX_DEPTH (MAX_DEPTH),
        .EFF_DIMS  (EFF_DIMS)
    ) u_rank (
        .clk          (clk),
        .rst_n        (rst_n),
        .zero_tile_en (zero_reg),
        .neg_half_en  (neg_reg),
        .valid_in     (s3_valid),
        .ready_up     (s4_ready),
        .ctl_in       (s3_ctl),
        .acc_in       (s3_acc),
        .n_in         (s3_n),
        .ready_dn     (!out_stall),
        .valid_out    (out_valid),
        .found_out    (found),
        .index_out    (tile_index)
    );

endmodule

// ===== design/ptidx_prep.sv =====
// First pipeline stage: clamps the configuration, checks coordinate ranges
// and offsets each coordinate by depth. Depends on ptidx_pkg.
module ptidx_prep #(
    parameter int MAX_DEPTH = 15,
    parameter int EFF_DIMS  = 3,
    localparam int GMAX = 2 * MAX_DEPTH + 1,
    localparam int DW   = $clog2(MAX_DEPTH + 1),
    localparam int GW   = $clog2(GMAX + 1),
    localparam int UW   = $clog2(GMAX),
    localparam int VW   = $clog2(GMAX ** EFF_DIMS + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [ptidx_pkg::DEPTH_W-1:0]        cfg_depth,
    input  logic [ptidx_pkg::DIMS_W-1:0]         cfg_dims,
    input  logic                                 valid_in,
    output logic                                 ready_up,
    input  logic signed [ptidx_pkg::COORD_W-1:0] coord [ptidx_pkg::NUM_COORDS],
    input  logic                                 ready_dn,
    output logic                                 valid_out,
    output ptidx_pkg::ptidx_ctl_t                ctl_out,
    output logic [GW-1:0]                        g_out,
    output logic [VW-1:0]                        acc_out,
    output logic [VW-1:0]                        n_out,
    output logic [UW-1:0]                        u_out [ptidx_pkg::NUM_COORDS]
);
    import ptidx_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic             load;
    logic [DW-1:0]    d;
    logic [GW-1:0]    g_next;
    ptidx_ctl_t       ctl_next;
    ptidx_ctl_t       ctl_reg;
    logic [GW-1:0]    g_reg;
    logic [VW-1:0]    acc_reg;
    logic [VW-1:0]    n_reg;
    logic [UW-1:0]    u_next [NUM_COORDS];
    logic [UW-1:0]    u_reg  [NUM_COORDS];

    assign ready_up   = !valid_reg || ready_dn;
    assign load       = valid_in && ready_up;
    assign valid_next = ready_up ? valid_in : valid_reg;

    always_comb
    begin
        logic [DIMS_W-1:0]  dims;
        logic               ok;
        logic signed [5:0]  xs;
        logic signed [5:0]  ds;
        logic signed [5:0]  sum;

        if (cfg_depth > DEPTH_W'(MAX_DEPTH))
        begin
            d = DW'(MAX_DEPTH);
        end
        else
        begin
            d = DW'(cfg_depth);
        end
        g_next = GW'({d, 1'b1});

        if (cfg_dims == '0)
        begin
            dims = DIMS_W'(1);
        end
        else if (cfg_dims > DIMS_W'(EFF_DIMS))
        begin
            dims = DIMS_W'(EFF_DIMS);
        end
        else
        begin
            dims = cfg_dims;
        end

        ok = 1'b1;
        ds = signed'({2'b00, DEPTH_W'(d)});
        for (int j = 0; j < NUM_COORDS; j++)
        begin
            xs        = signed'({coord[j][COORD_W-1], coord[j]});
            sum       = xs + ds;
            u_next[j] = UW'(sum);
            if (DIMS_W'(j) < dims && (sum < 0 || xs > ds))
            begin
                ok = 1'b0;
            end
        end

        ctl_next.inrange = ok;
        ctl_next.dims    = dims;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= ctl_next;
            g_reg   <= g_next;
            acc_reg <= VW'(u_next[0]);
            n_reg   <= VW'(g_next);
            u_reg   <= u_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign g_out     = g_reg;
    assign acc_out   = acc_reg;
    assign n_out     = n_reg;
    assign u_out     = u_reg;

endmodule

// ===== design/ptidx_mac.sv =====
// One Horner step of the mixed-radix value: acc = acc * g + u[STEP], and
// the tile count n = n * g, when the coordinate is in use. Depends on ptidx_pkg.
module ptidx_mac #(
    parameter int MAX_DEPTH = 15,
    parameter int EFF_DIMS  = 3,
    parameter int STEP      = 1,
    localparam int GMAX = 2 * MAX_DEPTH + 1,
    localparam int GW   = $clog2(GMAX + 1),
    localparam int UW   = $clog2(GMAX),
    localparam int VW   = $clog2(GMAX ** EFF_DIMS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    output logic                  ready_up,
    input  ptidx_pkg::ptidx_ctl_t ctl_in,
    input  logic [GW-1:0]         g_in,
    input  logic [VW-1:0]         acc_in,
    input  logic [VW-1:0]         n_in,
    input  logic [UW-1:0]         u_in  [ptidx_pkg::NUM_COORDS],
    input  logic                  ready_dn,
    output logic                  valid_out,
    output ptidx_pkg::ptidx_ctl_t ctl_out,
    output logic [GW-1:0]         g_out,
    output logic [VW-1:0]         acc_out,
    output logic [VW-1:0]         n_out,
    output logic [UW-1:0]         u_out [ptidx_pkg::NUM_COORDS]
);
    import ptidx_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic             load;
    logic [VW+GW-1:0] prod_acc;
    logic [VW+GW-1:0] prod_n;
    logic [VW-1:0]    acc_next;
    logic [VW-1:0]    n_next;
    ptidx_ctl_t       ctl_reg;
    logic [GW-1:0]    g_reg;
    logic [VW-1:0]    acc_reg;
    logic [VW-1:0]    n_reg;
    logic [UW-1:0]    u_reg [NUM_COORDS];

    assign ready_up   = !valid_reg || ready_dn;
    assign load       = valid_in && ready_up;
    assign valid_next = ready_up ? valid_in : valid_reg;

    assign prod_acc = {{GW{1'b0}}, acc_in} * {{VW{1'b0}}, g_in};
    assign prod_n   = {{GW{1'b0}}, n_in} * {{VW{1'b0}}, g_in};

    always_comb
    begin
        if (ctl_in.dims > DIMS_W'(STEP))
        begin
            acc_next = VW'(prod_acc + (VW+GW)'(u_in[STEP]));
            n_next   = VW'(prod_n);
        end
        else
        begin
            acc_next = acc_in;
            n_next   = n_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= ctl_in;
            g_reg   <= g_in;
            acc_reg <= acc_next;
            n_reg   <= n_next;
            u_reg   <= u_in;
        end
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign g_out     = g_reg;
    assign acc_out   = acc_reg;
    assign n_out     = n_reg;
    assign u_out     = u_reg;

endmodule

// ===== design/ptidx_rank.sv =====
// Last pipeline stage: compares the mixed-radix value with the centre tile
// and forms the row index; holds the output register. Depends on ptidx_pkg.
module ptidx_rank #(
    parameter int MAX_DEPTH = 15,
    parameter int EFF_DIMS  = 3,
    localparam int GMAX = 2 * MAX_DEPTH + 1,
    localparam int VW   = $clog2(GMAX ** EFF_DIMS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          zero_tile_en,
    input  logic                          neg_half_en,
    input  logic                          valid_in,
    output logic                          ready_up,
    input  ptidx_pkg::ptidx_ctl_t         ctl_in,
    input  logic [VW-1:0]                 acc_in,
    input  logic [VW-1:0]                 n_in,
    input  logic                          ready_dn,
    output logic                          valid_out,
    output logic                          found_out,
    output logic [ptidx_pkg::INDEX_W-1:0] index_out
);
    import ptidx_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic               load;
    logic [VW-1:0]      centre;
    logic [VW-1:0]      iz;
    logic               found_next;
    logic [VW-1:0]      row_next;
    logic               found_reg;
    logic [INDEX_W-1:0] index_reg;

    assign ready_up   = !valid_reg || ready_dn;
    assign load       = valid_in && ready_up;
    assign valid_next = ready_up ? valid_in : valid_reg;

    // The tile count is odd, so the centre value (n - 1) / 2 is n >> 1.
    assign centre = n_in >> 1;
    assign iz     = VW'(zero_tile_en);

    always_comb
    begin
        found_next = 1'b0;
        row_next   = '0;
        if (ctl_in.inrange)
        begin
            if (acc_in == centre)
            begin
                found_next = zero_tile_en;
            end
            else if (acc_in > centre)
            begin
                found_next = 1'b1;
                row_next   = acc_in - centre - VW'(1) + iz;
            end
            else
            begin
                // Negated half: iz + centre + (centre - v - 1) = iz + n - 2 - v.
                found_next = neg_half_en;
                if (neg_half_en)
                begin
                    row_next = n_in - acc_in - VW'(2) + iz;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg <= found_next;
            index_reg <= INDEX_W'(row_next);
        end
    end

    assign valid_out = valid_reg;
    assign found_out = found_reg;
    assign index_out = index_reg;

endmodule

// ===== verif/tb_periodic_tile_index_unit.sv =====
// Self-checking testbench for periodic_tile_index_unit: table-driven directed items, then
// random items under many register settings, each compared against a predictor of the index.
// Depends on ptidx_pkg and the periodic_tile_index_unit RTL; needs no files or arguments.
module tb_periodic_tile_index_unit;
    import ptidx_pkg::*;

    localparam int MAX_DIMS          = 3;
    localparam int MAX_DEPTH         = 15;
    // Quiet time after the last result, before the registers change or the run ends.
    localparam int DRAIN_CYCLES      = 8;
    localparam int HOLD_CYCLES       = 40;
    localparam int NUM_SEGMENTS      = 14;
    localparam int ITEMS_PER_SEGMENT = 100;
    localparam int NUM_PROBES        = 25;
    localparam int CYCLE_LIMIT       = 300000;

    // One result of a lookup, as the unit presents it.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } tile_result_t;

    // One row of the directed table. When reconfig is set, the four register
    // values are written before the item; otherwise they only document the
    // setting in force. When known is set, the expected result is the one typed
    // into the row; otherwise the predictor supplies it.
    typedef struct packed {
        bit                 reconfig;
        logic [DEPTH_W-1:0] depth;
        logic [DIMS_W-1:0]  dims;
        logic               zero;
        logic               neg;
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] c1;
        logic [COORD_W-1:0] c2;
        bit                 known;
        logic               found;
        logic [INDEX_W-1:0] index;
    } probe_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_DEPTH;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [COORD_W-1:0] coord_0 = '0;
    logic signed [COORD_W-1:0] coord_1 = '0;
    logic signed [COORD_W-1:0] coord_2 = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      found;
    logic [INDEX_W-1:0]        tile_index;

    // The testbench's own copy of the registers, at their reset values.
    logic [DEPTH_W-1:0]        tile_depth = 4'd1;
    logic [DIMS_W-1:0]         tile_dims = 2'd3;
    logic                      tile_zero_en = 1'b1;
    logic                      tile_neg_en = 1'b1;

    tile_result_t              pending_results[$];
    probe_t                    probes [0:NUM_PROBES-1];
    int                        mismatch_count = 0;
    int                        cycle_count = 0;
    int                        send_idle_pct = 8;
    int                        recv_idle_pct = 83;
    int                        hold_requests = 0;
    int                        holds_served = 0;
    int                        hold_left = 0;

    periodic_tile_index_unit #(
        .MAX_DIMS  (MAX_DIMS),
        .MAX_DEPTH (MAX_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .coord_0    (coord_0),
        .coord_1    (coord_1),
        .coord_2    (coord_2),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .tile_index (tile_index)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Closed-form position of a tile in the list for the current setting. The
    // used coordinates form a mixed-radix number in base 2*depth+1, offset so
    // that every digit is non-negative; the zero tile sits exactly in the middle
    // of that range. Values above the middle are the positive half in odometer
    // order, values below it are the negated half, counted outward.
    function automatic tile_result_t locate_tile(input logic signed [COORD_W-1:0] c0,
                                                 input logic signed [COORD_W-1:0] c1,
                                                 input logic signed [COORD_W-1:0] c2);
        logic signed [COORD_W-1:0] coords [NUM_COORDS];
        int                        d;
        int                        dims;
        int                        g;
        int                        x;
        longint unsigned           v;
        longint unsigned           n;
        longint unsigned           centre;
        longint unsigned           row;
        bit                        hit;
        tile_result_t              res;

        coords[0] = c0;
        coords[1] = c1;
        coords[2] = c2;
        d = (int'(tile_depth) > MAX_DEPTH) ? MAX_DEPTH : int'(tile_depth);
        dims = (tile_dims == 0) ? 1 : int'(tile_dims);
        if (dims > MAX_DIMS)
        begin
            dims = MAX_DIMS;
        end
        if (dims > NUM_COORDS)
        begin
            dims = NUM_COORDS;
        end
        g = 2 * d + 1;
        v = 0;
        n = 1;
        hit = 1'b1;
        for (int j = 0; j < dims; j++)
        begin
            x = int'(coords[j]);
            if (x < -d || x > d)
            begin
                hit = 1'b0;
            end
            else
            begin
                v = v * g + longint'(x + d);
            end
            n = n * g;
        end
        centre = (n - 1) / 2;
        row = 0;
        if (hit)
        begin
            if (v == centre)
            begin
                hit = tile_zero_en;
            end
            else if (v > centre)
            begin
                row = tile_zero_en + (v - centre - 1);
            end
            else
            begin
                // The negated half is as long as the positive half, which is centre.
                hit = tile_neg_en;
                row = tile_zero_en + centre + (centre - v - 1);
            end
        end
        if (!hit)
        begin
            row = 0;
        end
        res.found = hit;
        res.index = row[INDEX_W-1:0];
        return res;
    endfunction

    // Mostly coordinates inside the current bound, so that most items find a
    // row; some sit right on or just past the bound, and the rest are any
    // five-bit value at all.
    function automatic logic [COORD_W-1:0] random_coord(input int d);
        int pick;
        int mag;

        pick = $urandom_range(99);
        if (pick < 70)
        begin
            return COORD_W'(int'($urandom_range(2 * d)) - d);
        end
        else if (pick < 82)
        begin
            mag = d + int'($urandom_range(1));
            return COORD_W'($urandom_range(1) ? mag : -mag);
        end
        return COORD_W'($urandom_range(31));
    endfunction

    // Offers one item, with a random gap before it at the sender's idle rate,
    // and returns at the edge where it is accepted. The expected result is
    // queued at that same edge.
    task automatic offer_tile(input logic [COORD_W-1:0] c0,
                              input logic [COORD_W-1:0] c1,
                              input logic [COORD_W-1:0] c2,
                              input bit known,
                              input tile_result_t known_res);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        coord_0 <= c0;
        coord_1 <= c1;
        coord_2 <= c2;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_results.push_back(known ? known_res : locate_tile(c0, c1, c2));
    endtask

    // Lets the pipeline run empty: no item is offered until every expected
    // result has come out, and then a quiet time follows.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers on back-to-back cycles once the unit is idle.
    task automatic apply_setting(input logic [DEPTH_W-1:0] d,
                                 input logic [DIMS_W-1:0] dims,
                                 input logic zero,
                                 input logic neg);
        drain_pipeline();
        cfg_we <= 1'b1;
        cfg_index <= REG_DEPTH;
        cfg_wdata <= CFG_DATA_W'(d);
        @(posedge clk);
        cfg_index <= REG_ACTIVE_DIMS;
        cfg_wdata <= CFG_DATA_W'(dims);
        @(posedge clk);
        cfg_index <= REG_ZERO_TILE;
        cfg_wdata <= CFG_DATA_W'(zero);
        @(posedge clk);
        cfg_index <= REG_NEG_HALF;
        cfg_wdata <= CFG_DATA_W'(neg);
        @(posedge clk);
        cfg_we <= 1'b0;
        tile_depth = d;
        tile_dims = dims;
        tile_zero_en = zero;
        tile_neg_en = neg;
    endtask

    // Receiver: stalls at random at its idle rate, except that each new hold
    // request makes it stall without a break while hold_left, loaded from
    // HOLD_CYCLES, counts down. The sender keeps offering during a hold, so the
    // pipeline fills and the unit must push back on its input.
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        tile_result_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: found %0d, tile_index %0d",
                       found, tile_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                begin
                    $error("found mismatch: expected %0d, got %0d", want.found, found);
                    mismatch_count++;
                end
                if (tile_index !== want.index)
                begin
                    $error("tile_index mismatch: expected %0d, got %0d",
                           want.index, tile_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        tile_result_t known_res;
        logic [DEPTH_W-1:0] d;
        logic [DIMS_W-1:0] dims;
        logic zero;
        logic neg;
        int phase;

        // Directed table. The reset setting comes first: depth 1 over three
        // coordinates gives 27 tiles with the zero tile in the middle.
        // Then zero tile and negated half excluded, depth zero where only the
        // zero tile exists, the widest list whose last row is the largest
        // index, and zero dimensions behaving as one.
        probes = '{
            '{0, 1, 3, 1, 1,   0,   0,   0, 1, 1,     0},
            '{0, 1, 3, 1, 1,   0,   0,   1, 1, 1,     1},
            '{0, 1, 3, 1, 1,   1,   1,   1, 1, 1,    13},
            '{0, 1, 3, 1, 1,   0,   0,  -1, 1, 1,    14},
            '{0, 1, 3, 1, 1,  -1,  -1,  -1, 1, 1,    26},
            '{0, 1, 3, 1, 1,   2,   0,   0, 1, 0,     0},
            '{0, 1, 3, 1, 1, -16,   0,   0, 1, 0,     0},
            '{0, 1, 3, 1, 1,  15,  15,  15, 1, 0,     0},
            '{0, 1, 3, 1, 1,   0,   0, -16, 1, 0,     0},
            '{0, 1, 3, 1, 1,   1,  -1,   0, 0, 0,     0},
            '{0, 1, 3, 1, 1,  -1,   1,   0, 0, 0,     0},
            '{0, 1, 3, 1, 1,   0,   1,  -1, 0, 0,     0},
            '{1, 1, 3, 0, 0,   0,   0,   0, 1, 0,     0},
            '{0, 1, 3, 0, 0,   0,   0,   1, 1, 1,     0},
            '{0, 1, 3, 0, 0,   0,   0,  -1, 1, 0,     0},
            '{0, 1, 3, 0, 0,   1,   1,   1, 1, 1,    12},
            '{1, 0, 1, 1, 1,   0,   7,  -9, 1, 1,     0},
            '{0, 0, 1, 1, 1,   1,   0,   0, 1, 0,     0},
            '{0, 0, 1, 1, 1,  -1,   0,   0, 1, 0,     0},
            '{1, 15, 3, 1, 1, 15,  15,  15, 1, 1, 14895},
            '{0, 15, 3, 1, 1, -15, -15, -15, 1, 1, 29790},
            '{0, 15, 3, 1, 1, -16,   0,   0, 1, 0,     0},
            '{1, 15, 0, 1, 1,   5, -16,  15, 1, 1,     5},
            '{1, 2, 2, 0, 1,  -2,   2,   9, 0, 0,     0},
            '{0, 2, 2, 0, 1,   1,  -2,   0, 0, 0,     0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            if (probes[i].reconfig)
            begin
                apply_setting(probes[i].depth, probes[i].dims, probes[i].zero,
                              probes[i].neg);
            end
            known_res.found = probes[i].found;
            known_res.index = probes[i].index;
            offer_tile(probes[i].c0, probes[i].c1, probes[i].c2, probes[i].known,
                       known_res);
        end

        // Random part: each segment runs under its own register setting. The
        // first few settings are the extremes; the rest are drawn at random.
        // The run is split in thirds by idle pattern: receiver mostly stalled,
        // then sender mostly idle, then no idling at all.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            phase = seg * 3 / NUM_SEGMENTS;
            case (seg)
                0: begin d = 4'd0;  dims = 2'd1; zero = 1'b0; neg = 1'b0; end
                1: begin d = 4'd15; dims = 2'd3; zero = 1'b1; neg = 1'b1; end
                2: begin d = 4'd15; dims = 2'd0; zero = 1'b0; neg = 1'b1; end
                3: begin d = 4'd1;  dims = 2'd2; zero = 1'b1; neg = 1'b0; end
                default:
                begin
                    d = DEPTH_W'($urandom_range(15));
                    dims = DIMS_W'($urandom_range(3));
                    zero = 1'($urandom_range(1));
                    neg = 1'($urandom_range(1));
                end
            endcase
            apply_setting(d, dims, zero, neg);
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 83 : 0;
            recv_idle_pct <= (phase == 0) ? 83 : (phase == 1) ? 8 : 0;
            // Ask for a long receiver hold at the start of the first segment
            // of the first and last thirds, while items keep arriving.
            if (seg == 0 || (phase == 2 && (seg - 1) * 3 / NUM_SEGMENTS != 2))
            begin
                hold_requests <= hold_requests + 1;
            end
            for (int k = 0; k < ITEMS_PER_SEGMENT; k++)
            begin
                offer_tile(random_coord(int'(tile_depth)), random_coord(int'(tile_depth)),
                           random_coord(int'(tile_depth)), 1'b0, known_res);
            end
        end

        drain_pipeline();
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
